// ===== sv/hcbd_pkg.sv =====
`default_nettype none

package hcbd_pkg;

    localparam int LEN_BITS_DEF = 32;
    localparam int CFG_IDX_W = 4;
    localparam logic [31:0] BODY_LIMIT_RST = 32'd1048576;
    localparam logic [4:0] MAX_DIGITS_RST = 5'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS = 4'd1;

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [4:0] HEX_BAD = 5'd16;
    localparam logic [4:0] HEX_ALPHA = 5'd10;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_EXT     = 3'd1,
        PH_SIZE_LF = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATA_CR = 3'd4,
        PH_DATA_LF = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERR     = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FRAMING   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        t_status     status;
        logic [31:0] body_len;
    } t_out_item;

    typedef struct packed {
        logic [31:0] limit;
        logic [4:0]  max_digits;
    } t_cfg;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = HEX_BAD;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = 5'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = 5'(b - 8'h61) + HEX_ALPHA;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = 5'(b - 8'h41) + HEX_ALPHA;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/hcbd_in_reg.sv =====
`default_nettype none

module hcbd_in_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  hcbd_pkg::t_in_item i_data,
    output logic               o_stall,
    output logic               o_valid,
    output hcbd_pkg::t_in_item o_data,
    input  wire                i_ready
);
    import hcbd_pkg::*;

    logic     r_valid;
    t_in_item r_data;
    logic     load;

    assign load    = !r_valid || i_ready;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/hcbd_step.sv =====
`default_nettype none

module hcbd_step #(
    parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hcbd_pkg::t_cfg      i_cfg,
    input  wire                 i_fire,
    input  hcbd_pkg::t_in_item  i_item,
    output logic                o_res_valid,
    output hcbd_pkg::t_out_item o_res
);
    import hcbd_pkg::*;

    localparam int CW = (LEN_BITS + 4 > 32) ? LEN_BITS + 4 : 32;
    localparam int OW = (LEN_BITS > 32) ? LEN_BITS : 32;

    t_phase              r_phase, n_phase;
    logic [LEN_BITS-1:0] r_size_accum, n_size_accum;
    logic                r_size_over, n_size_over;
    logic [4:0]          r_digit_count, n_digit_count;
    logic [LEN_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [LEN_BITS-1:0] r_total_len, n_total_len;

    logic [7:0]    b;
    logic [4:0]    nib;
    logic [5:0]    dig_next;
    logic [CW-1:0] lim_c;
    logic [CW-1:0] val_c;
    logic [CW-1:0] sum_c;
    logic [OW-1:0] len_w;
    logic          err;
    t_status       err_code;
    logic          data;

    assign b        = i_item.in_byte;
    assign nib      = hex_value(b);
    assign dig_next = {1'b0, r_digit_count} + 6'd1;
    assign lim_c    = CW'(i_cfg.limit);
    assign val_c    = CW'({r_size_accum, 4'b0000}) | CW'(nib[3:0]);
    assign sum_c    = CW'(r_total_len) + CW'(r_size_accum);

    always_comb begin
        n_phase       = r_phase;
        n_size_accum  = r_size_accum;
        n_size_over   = r_size_over;
        n_digit_count = r_digit_count;
        n_bytes_left  = r_bytes_left;
        n_total_len   = r_total_len;
        err           = 1'b0;
        err_code      = ST_FRAMING;
        data          = 1'b0;
        o_res_valid   = 1'b0;
        o_res         = '{kind: KIND_DATA, out_byte: 8'd0, status: ST_OK, body_len: 32'd0};
        len_w         = '0;

        unique case (r_phase)
            PH_SIZE: begin
                if (b == CH_CR || b == CH_SEMI) begin
                    if (r_digit_count == 5'd0) begin
                        err = 1'b1;
                    end else begin
                        n_phase = (b == CH_CR) ? PH_SIZE_LF : PH_EXT;
                    end
                end else if (nib[4] || dig_next > {1'b0, i_cfg.max_digits}) begin
                    err = 1'b1;
                end else begin
                    n_digit_count = dig_next[4:0];
                    if (!r_size_over) begin
                        if (val_c > lim_c) begin
                            n_size_over = 1'b1;
                        end else begin
                            n_size_accum = val_c[LEN_BITS-1:0];
                        end
                    end
                end
            end
            PH_EXT: begin
                if (b == CH_CR) begin
                    n_phase = PH_SIZE_LF;
                end
            end
            PH_SIZE_LF: begin
                if (b != CH_LF) begin
                    err = 1'b1;
                end else if (r_size_over) begin
                    err      = 1'b1;
                    err_code = ST_TOO_LARGE;
                end else if (r_size_accum == '0) begin
                    n_phase = PH_DONE;
                end else if (sum_c > lim_c) begin
                    err      = 1'b1;
                    err_code = ST_TOO_LARGE;
                end else begin
                    n_bytes_left = r_size_accum;
                    n_phase      = PH_DATA;
                end
                n_size_accum  = '0;
                n_size_over   = 1'b0;
                n_digit_count = 5'd0;
            end
            PH_DATA: begin
                if (r_bytes_left != '0) begin
                    n_bytes_left = r_bytes_left - 1'b1;
                    n_total_len  = r_total_len + 1'b1;
                    data         = 1'b1;
                end
                if (n_bytes_left == '0) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (b == CH_CR) begin
                    n_phase = PH_DATA_LF;
                end else begin
                    err = 1'b1;
                end
            end
            PH_DATA_LF: begin
                if (b == CH_LF) begin
                    n_phase       = PH_SIZE;
                    n_size_accum  = '0;
                    n_size_over   = 1'b0;
                    n_digit_count = 5'd0;
                end else begin
                    err = 1'b1;
                end
            end
            PH_DONE, PH_ERR: begin
            end
            default: begin
            end
        endcase

        if (i_item.last_in) begin
            if (r_phase != PH_ERR) begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_STATUS;
                if (err) begin
                    o_res.status = err_code;
                end else if (n_phase == PH_DONE
                             || (n_phase == PH_SIZE && n_digit_count == 5'd0)) begin
                    len_w          = OW'(n_total_len);
                    o_res.status   = ST_OK;
                    o_res.body_len = len_w[31:0];
                end else if (n_phase == PH_DATA) begin
                    o_res.status = ST_TRUNCATED;
                end else begin
                    o_res.status = ST_FRAMING;
                end
            end
            n_phase       = PH_SIZE;
            n_size_accum  = '0;
            n_size_over   = 1'b0;
            n_digit_count = 5'd0;
            n_bytes_left  = '0;
            n_total_len   = '0;
        end else if (err) begin
            n_phase       = PH_ERR;
            n_size_accum  = '0;
            n_size_over   = 1'b0;
            n_digit_count = 5'd0;
            n_bytes_left  = '0;
            o_res_valid   = 1'b1;
            o_res.kind    = KIND_STATUS;
            o_res.status  = err_code;
        end else if (data) begin
            o_res_valid    = 1'b1;
            o_res.out_byte = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SIZE;
            r_size_accum  <= '0;
            r_size_over   <= 1'b0;
            r_digit_count <= 5'd0;
            r_bytes_left  <= '0;
            r_total_len   <= '0;
        end else if (i_fire) begin
            r_phase       <= n_phase;
            r_size_accum  <= n_size_accum;
            r_size_over   <= n_size_over;
            r_digit_count <= n_digit_count;
            r_bytes_left  <= n_bytes_left;
            r_total_len   <= n_total_len;
        end
    end

    a_data_from_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && o_res.kind == KIND_DATA |-> r_phase == PH_DATA)
        else $error("data transfer outside the data phase");

    a_silent_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_phase == PH_ERR |-> !o_res_valid)
        else $error("result produced after an error");

    a_error_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res_valid && o_res.kind == KIND_STATUS && !i_item.last_in
        |=> r_phase == PH_ERR)
        else $error("error status without entering the error phase");

    a_size_line_no_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SIZE || r_phase == PH_EXT || r_phase == PH_SIZE_LF
        |-> r_bytes_left == '0)
        else $error("data still owed inside a size line");

endmodule

`default_nettype wire

// ===== sv/hcbd_out_reg.sv =====
`default_nettype none

module hcbd_out_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire                 i_res_valid,
    input  hcbd_pkg::t_out_item i_res,
    output logic                o_ready,
    output logic                o_valid,
    output hcbd_pkg::t_out_item o_data,
    input  wire                 i_stall
);
    import hcbd_pkg::*;

    logic      r_valid;
    t_out_item r_data;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load && i_res_valid) begin
            r_data <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/http_chunked_body_decoder_top.sv =====
// Streaming HTTP/1.1 chunked body decoder. Takes one encoded byte per cycle
// while the output side does not stall and produces at most one result per
// byte: a decoded data byte, or a final status (ok with the decoded length,
// framing error, body too large, truncated chunk). Each byte passes through the
// input register and then the result register, with the per-byte parse between
// them combinational. The first error is reported at once and later bytes are
// dropped up to the byte flagged last, after which the decoder re-arms. Write
// the limits only while no byte is in flight.
`default_nettype none

module http_chunked_body_decoder_top #(
    parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  hcbd_pkg::t_in_item                 i_data,
    output logic                               o_stall,
    output logic                               o_valid,
    output hcbd_pkg::t_out_item                o_data,
    input  wire                                i_stall,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [hcbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [31:0]                        i_cfg_data
);
    import hcbd_pkg::*;

    localparam int WIDE = (LEN_BITS > 32) ? LEN_BITS : 32;
    localparam logic [WIDE-1:0] MASK = (WIDE'(1) << LEN_BITS) - WIDE'(1);
    localparam logic [WIDE-1:0] LIMIT_RST_W =
        (WIDE'(BODY_LIMIT_RST) > MASK) ? MASK : WIDE'(BODY_LIMIT_RST);

    logic [31:0]   r_limit;
    logic [4:0]    r_max_digits;
    logic [WIDE-1:0] cfg_w;
    logic [WIDE-1:0] cfg_lim;
    t_cfg          cfg;

    logic          stg_valid;
    t_in_item      stg_item;
    logic          out_ready;
    logic          fire;
    logic          res_valid;
    t_out_item     res;

    assign o_cfg_ready = 1'b1;
    assign cfg_w       = WIDE'(i_cfg_data);
    assign cfg_lim     = (cfg_w > MASK) ? MASK : cfg_w;
    assign cfg         = '{limit: r_limit, max_digits: r_max_digits};
    assign fire        = stg_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RST_W[31:0];
            r_max_digits <= MAX_DIGITS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BODY_LIMIT: r_limit <= cfg_lim[31:0];
                CFG_MAX_DIGITS: r_max_digits <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    hcbd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (stg_valid),
        .o_data  (stg_item),
        .i_ready (out_ready)
    );

    hcbd_step #(
        .LEN_BITS (LEN_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (fire),
        .i_item      (stg_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hcbd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule

`default_nettype wire
